FILE: rtl/core/assert_macros.svh
// assertion macros used by the core rtl file of the moving average reporter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define AMAR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("amar assertion failed");

// expression must never be true outside reset
`define AMAR_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("amar assertion failed");

`else

`define AMAR_ASSERT(lbl, clk, rst_n, prop)
`define AMAR_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

FILE: rtl/core/amar_pkg.sv
// shared constants and types of the moving average reporter
package amar_pkg;

    // default structure
    localparam int AVG_DEPTH_DEF   = 8;
    localparam int SAMPLE_BITS_DEF = 10;

    // fixed field widths
    localparam int TIME_W   = 32;
    localparam int IN_W     = 10;
    localparam int VALUE_W  = 10;
    localparam int SENS_W   = 8;
    localparam int SINT_W   = 8;
    localparam int RINT_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [SENS_W-1:0] SENS_RST = 8'd0;
    localparam logic [SINT_W-1:0] SINT_RST = 8'd10;
    localparam logic [RINT_W-1:0] RINT_RST = 16'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSITIVITY     = 2'd0,
        CFG_SAMPLE_INTERVAL = 2'd1,
        CFG_REPORT_INTERVAL = 2'd2
    } t_cfg_idx;

endpackage

FILE: rtl/core/amar_cell.sv
// one sample cell of the averaging chain
module amar_cell #(
    parameter int SAMPLE_BITS = amar_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  logic [SAMPLE_BITS-1:0] i_d,
    output logic [SAMPLE_BITS-1:0] o_q
);

    logic [SAMPLE_BITS-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

FILE: rtl/core/amar_ring.sv
// chain of sample cells, newest enters at the head, oldest leaves at the tail
module amar_ring #(
    parameter int AVG_DEPTH   = amar_pkg::AVG_DEPTH_DEF,
    parameter int SAMPLE_BITS = amar_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [SAMPLE_BITS-1:0] o_oldest
);

    logic [SAMPLE_BITS-1:0] w_link [0:AVG_DEPTH];

    assign w_link[0] = i_sample;

    for (genvar g = 0; g < AVG_DEPTH; g++) begin : g_cell
        amar_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_shift(i_shift),
            .i_d    (w_link[g]),
            .o_q    (w_link[g+1])
        );
    end

    assign o_oldest = w_link[AVG_DEPTH];

endmodule

FILE: rtl/core/analog_moving_average_reporter_core.sv
// moving average reporter top level: timing, running sum, average and deadband report
// throughput: one item per cycle while o_ready is high; timing compare, sum update and cell shift share that cycle
// a report reaches o_valid through the check, average and output registers after its item is accepted
//   (accept stage, reciprocal multiply stage, deadband compare into the output register)
// the output register parts the two sides: items keep coming while a report waits,
//   until two more due report checks are held behind it
// reset: synchronous active low, clears cells, sum, times and valid flags
`include "assert_macros.svh"

module analog_moving_average_reporter_core #(
    parameter int AVG_DEPTH   = amar_pkg::AVG_DEPTH_DEF,
    parameter int SAMPLE_BITS = amar_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input item channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [amar_pkg::TIME_W-1:0]     i_now_ms,
    input  logic [amar_pkg::IN_W-1:0]       i_sample,
    // result item channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [amar_pkg::VALUE_W-1:0]    o_value,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [amar_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [amar_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TIME_W  = amar_pkg::TIME_W;
    localparam int VALUE_W = amar_pkg::VALUE_W;
    localparam int SENS_W  = amar_pkg::SENS_W;
    localparam int SINT_W  = amar_pkg::SINT_W;
    localparam int RINT_W  = amar_pkg::RINT_W;

    // sum and reciprocal sizing: quotient = (sum * RECIP) >> SHIFT is exact for any sum
    localparam int L_W     = $clog2(AVG_DEPTH);
    localparam int SUM_W   = SAMPLE_BITS + L_W;
    localparam int SHIFT   = SUM_W + L_W;
    localparam int M_W     = SUM_W + 1;
    localparam int PROD_W  = SUM_W + M_W;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam longint unsigned SUM_MAX_L = AVG_DEPTH * ((64'd1 << SAMPLE_BITS) - 1);
    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(SUM_MAX_L);
    localparam logic [M_W-1:0]   RECIP_C = M_W'(RECIP);

    // configuration registers
    logic [SENS_W-1:0] r_sensitivity;
    logic [SINT_W-1:0] r_sample_int;
    logic [RINT_W-1:0] r_report_int;

    // filter state
    logic [SUM_W-1:0]   r_sum;
    logic [TIME_W-1:0]  r_last_sample_time;
    logic [TIME_W-1:0]  r_last_report_time;
    logic [VALUE_W-1:0] r_last_reported;

    // pipeline registers
    logic               r_a_v;
    logic [SUM_W-1:0]   r_a_sum;
    logic               r_b_v;
    logic [VALUE_W-1:0] r_b_avg;
    logic               r_out_v;
    logic [VALUE_W-1:0] r_out_value;

    // accept stage signals
    logic                   w_acc;
    logic [SAMPLE_BITS-1:0] w_sample;
    logic [SAMPLE_BITS-1:0] w_oldest;
    logic [TIME_W-1:0]      w_elapsed_s;
    logic [TIME_W-1:0]      w_elapsed_r;
    logic                   w_samp_due;
    logic                   w_rep_due;
    logic [SUM_W-1:0]       n_sum;

    // stage readiness, back to front
    logic w_ready_c;
    logic w_ready_b;
    logic w_ready_a;

    // multiply and deadband compare
    logic [PROD_W-1:0]  w_prod;
    logic [VALUE_W-1:0] w_diff;
    logic               w_fire_c;
    logic               w_pass;

    assign w_ready_c = !r_out_v || i_ready;
    assign w_ready_b = !r_b_v || w_ready_c;
    assign w_ready_a = !r_a_v || w_ready_b;

    assign o_ready     = w_ready_a;
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_valid && w_ready_a;

    // sample taken in its low bits, zero extended where the cells are wider
    assign w_sample = SAMPLE_BITS'(i_sample);

    // elapsed times wrap modulo 2^32, intervals must be strictly exceeded
    assign w_elapsed_s = i_now_ms - r_last_sample_time;
    assign w_elapsed_r = i_now_ms - r_last_report_time;
    assign w_samp_due  = w_elapsed_s > TIME_W'(r_sample_int);
    assign w_rep_due   = w_elapsed_r > TIME_W'(r_report_int);

    // oldest cell leaves the sum as the new sample enters it
    assign n_sum = w_samp_due ? (r_sum - SUM_W'(w_oldest) + SUM_W'(w_sample)) : r_sum;

    amar_ring #(
        .AVG_DEPTH  (AVG_DEPTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_acc && w_samp_due),
        .i_sample(w_sample),
        .o_oldest(w_oldest)
    );

    // divide by the depth through the reciprocal
    assign w_prod = {{M_W{1'b0}}, r_a_sum} * {{SUM_W{1'b0}}, RECIP_C};

    // absolute difference against the last reported value
    assign w_diff   = (r_b_avg >= r_last_reported) ? (r_b_avg - r_last_reported)
                                                   : (r_last_reported - r_b_avg);
    assign w_fire_c = r_b_v && w_ready_c;
    assign w_pass   = w_diff >= VALUE_W'(r_sensitivity);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensitivity      <= amar_pkg::SENS_RST;
            r_sample_int       <= amar_pkg::SINT_RST;
            r_report_int       <= amar_pkg::RINT_RST;
            r_sum              <= '0;
            r_last_sample_time <= '0;
            r_last_report_time <= '0;
            r_last_reported    <= '0;
            r_a_v              <= 1'b0;
            r_b_v              <= 1'b0;
            r_out_v            <= 1'b0;
        end else begin
            // register writes, indexes past the list are dropped
            if (i_cfg_valid) begin
                unique case (amar_pkg::t_cfg_idx'(i_cfg_index))
                    amar_pkg::CFG_SENSITIVITY: begin
                        r_sensitivity <= SENS_W'(i_cfg_data);
                    end
                    amar_pkg::CFG_SAMPLE_INTERVAL: begin
                        r_sample_int <= SINT_W'(i_cfg_data);
                    end
                    amar_pkg::CFG_REPORT_INTERVAL: begin
                        r_report_int <= RINT_W'(i_cfg_data);
                    end
                    default: begin
                    end
                endcase
            end

            // accept stage: sampling first, then the report check sees the new sum
            if (w_acc) begin
                if (w_samp_due) begin
                    r_sum              <= n_sum;
                    r_last_sample_time <= i_now_ms;
                end
                if (w_rep_due) begin
                    r_last_report_time <= i_now_ms;
                end
            end

            // check stage holds the sum snapshot for the multiplier
            if (w_acc && w_rep_due) begin
                r_a_v <= 1'b1;
            end else if (w_ready_b) begin
                r_a_v <= 1'b0;
            end

            // average stage
            if (w_ready_b) begin
                r_b_v <= r_a_v;
            end

            // deadband compare into the output register
            if (w_fire_c && w_pass) begin
                r_last_reported <= r_b_avg;
                r_out_v         <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc && w_rep_due) begin
            r_a_sum <= n_sum;
        end
        if (w_ready_b && r_a_v) begin
            r_b_avg <= VALUE_W'(w_prod[SHIFT +: SAMPLE_BITS]);
        end
        if (w_fire_c && w_pass) begin
            r_out_value <= r_b_avg;
        end
    end

    assign o_valid = r_out_v;
    assign o_value = r_out_value;

    // a waiting report is always the remembered value
    `AMAR_ASSERT_NEVER(a_out_is_last, i_clk, i_rst_n, r_out_v && (r_out_value != r_last_reported))
    // the running sum never exceeds a full ring of maximal samples
    `AMAR_ASSERT(a_sum_bound, i_clk, i_rst_n, r_sum <= SUM_MAX)
    // a due report check always reaches the multiply stage
    `AMAR_ASSERT(a_check_enters, i_clk, i_rst_n, (w_acc && w_rep_due) |=> r_a_v)
    // a blocked average holds until the output frees up
    `AMAR_ASSERT(a_avg_holds, i_clk, i_rst_n, (r_b_v && !w_ready_c) |=> (r_b_v && $stable(r_b_avg)))

endmodule
